[sv/nqbc_pkg.sv]
package nqbc_pkg;

  // Field widths of the request and result streams.
  localparam int BoardSizeW = 5;
  localparam int StartRowW  = 4;
  localparam int MaskInW    = 16;
  localparam int CountW     = 32;

  // Packed stream widths, rounded up to whole bytes.
  localparam int InFieldsW  = StartRowW + 3 * MaskInW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutDataW   = ((CountW + 7) / 8) * 8;

  // Reset value of the board size register.
  localparam logic [BoardSizeW-1:0] BoardSizeRst = BoardSizeW'(8);

  // Search sequencer states.
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StStep = 4'b0010,
    StPop  = 4'b0100,
    StDone = 4'b1000
  } state_e;

endpackage

[sv/nqbc_ram.sv]
module nqbc_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/nqueens_bitmask_counter_core.sv]
// Search: a queen placed or tried in the last row is handled in StStep; a
// return to a parent level passes StStep and then StPop (the stack memory read
// is registered), and the search ends in StDone, which holds the result.
// Throughput: one request at a time; the next request is taken once the
// result has been taken. A start row at or past the board finishes at once.
// Reset: asynchronous, active low; the block comes up idle with board size 8.
module nqueens_bitmask_counter_core #(
  parameter int MAX_N = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Board size register write.
  input  logic                               cfg_we_i,
  input  logic [nqbc_pkg::BoardSizeW-1:0]    cfg_wdata_i,
  // Request stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit up: start_row[3:0], taken_columns[19:4],
  // right_diagonals[35:20], left_diagonals[51:36], zero fill[55:52].
  input  logic [nqbc_pkg::InDataW-1:0]       s_axis_tdata,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, lowest bit up: solution_count[31:0].
  output logic [nqbc_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int RowW   = nqbc_pkg::BoardSizeW;
  localparam int MaskW  = (MAX_N > nqbc_pkg::MaskInW) ? MAX_N : nqbc_pkg::MaskInW;
  localparam int AddrW  = $clog2(MAX_N);
  localparam int EntryW = 4 * MaskW;
  localparam int CountW = nqbc_pkg::CountW;
  localparam int SrW    = nqbc_pkg::StartRowW;
  localparam int MiW    = nqbc_pkg::MaskInW;

  nqbc_pkg::state_e state_q, state_d;

  logic [RowW-1:0]   board_size_q;
  logic [RowW-1:0]   row_q, row_d;
  logic [RowW-1:0]   last_row_q, last_row_d;
  logic [AddrW-1:0]  depth_q, depth_d;
  logic [CountW-1:0] count_q, count_d;
  logic [MaskW-1:0]  full_q, full_d;
  logic [MaskW-1:0]  cur_free_q, cur_free_d;
  logic [MaskW-1:0]  cur_cols_q, cur_cols_d;
  logic [MaskW-1:0]  cur_rd_q, cur_rd_d;
  logic [MaskW-1:0]  cur_ld_q, cur_ld_d;

  // Request fields.
  logic [SrW-1:0] in_start;
  logic [MiW-1:0] in_cols, in_rd, in_ld;
  assign in_start = s_axis_tdata[SrW-1:0];
  assign in_cols  = s_axis_tdata[SrW+MiW-1:SrW];
  assign in_rd    = s_axis_tdata[SrW+2*MiW-1:SrW+MiW];
  assign in_ld    = s_axis_tdata[SrW+3*MiW-1:SrW+2*MiW];

  // Effective board size and the mask of columns on the board.
  logic [RowW-1:0]  n_w;
  logic [MaskW-1:0] full_w;
  assign n_w = (board_size_q > RowW'(MAX_N)) ? RowW'(MAX_N) : board_size_q;

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      full_w[i] = (RowW'(i) < n_w);
    end
  end

  // Shared placement unit: lowest free column and the child level it opens.
  logic [MaskW-1:0] low_bit, child_cols, child_rd, child_ld, child_free;
  assign low_bit    = cur_free_q & ((~cur_free_q) + MaskW'(1));
  assign child_cols = (cur_cols_q | low_bit) & full_q;
  assign child_rd   = (cur_rd_q | low_bit) >> 1;
  assign child_ld   = ((cur_ld_q | low_bit) << 1) & full_q;
  assign child_free = full_q & ~(child_cols | child_rd | child_ld);

  // Stack of parent levels.
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  assign ram_wdata = {cur_free_q ^ low_bit, cur_cols_q, cur_rd_q, cur_ld_q};
  assign ram_raddr = depth_q - AddrW'(1);

  nqbc_ram #(
    .Width (EntryW),
    .Depth (MAX_N)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (depth_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Search sequencer.
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    last_row_d = last_row_q;
    depth_d    = depth_q;
    count_d    = count_q;
    full_d     = full_q;
    cur_free_d = cur_free_q;
    cur_cols_d = cur_cols_q;
    cur_rd_d   = cur_rd_q;
    cur_ld_d   = cur_ld_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state_q)
      nqbc_pkg::StIdle: begin
        if (s_axis_tvalid) begin
          full_d     = full_w;
          last_row_d = n_w - RowW'(1);
          row_d      = RowW'(in_start);
          depth_d    = '0;
          count_d    = '0;
          cur_cols_d = MaskW'(in_cols) & full_w;
          cur_rd_d   = MaskW'(in_rd);
          cur_ld_d   = MaskW'(in_ld) & full_w;
          cur_free_d = full_w & ~((MaskW'(in_cols) & full_w) | MaskW'(in_rd)
                                  | (MaskW'(in_ld) & full_w));
          if (RowW'(in_start) < n_w) begin
            state_d = nqbc_pkg::StStep;
          end else begin
            state_d = nqbc_pkg::StDone;
          end
        end
      end
      nqbc_pkg::StStep: begin
        if (cur_free_q == '0) begin
          // Level exhausted: return to the parent or finish.
          if (depth_q == '0) begin
            state_d = nqbc_pkg::StDone;
          end else begin
            ram_re  = 1'b1;
            depth_d = depth_q - AddrW'(1);
            state_d = nqbc_pkg::StPop;
          end
        end else if (row_q == last_row_q) begin
          // A queen in the last row completes one solution.
          cur_free_d = cur_free_q ^ low_bit;
          if (count_q != '1) begin
            count_d = count_q + CountW'(1);
          end
        end else begin
          // Save the parent and descend one row.
          ram_we     = 1'b1;
          depth_d    = depth_q + AddrW'(1);
          row_d      = row_q + RowW'(1);
          cur_free_d = child_free;
          cur_cols_d = child_cols;
          cur_rd_d   = child_rd;
          cur_ld_d   = child_ld;
        end
      end
      nqbc_pkg::StPop: begin
        cur_free_d = ram_rdata[4*MaskW-1:3*MaskW];
        cur_cols_d = ram_rdata[3*MaskW-1:2*MaskW];
        cur_rd_d   = ram_rdata[2*MaskW-1:MaskW];
        cur_ld_d   = ram_rdata[MaskW-1:0];
        row_d      = row_q - RowW'(1);
        state_d    = nqbc_pkg::StStep;
      end
      nqbc_pkg::StDone: begin
        if (m_axis_tready) begin
          state_d = nqbc_pkg::StIdle;
        end
      end
      default: begin
        state_d = nqbc_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nqbc_pkg::StIdle;
      board_size_q <= nqbc_pkg::BoardSizeRst;
      depth_q      <= '0;
      count_q      <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        board_size_q <= cfg_wdata_i;
      end
    end
  end

  // Level payload registers.
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    last_row_q <= last_row_d;
    full_q     <= full_d;
    cur_free_q <= cur_free_d;
    cur_cols_q <= cur_cols_d;
    cur_rd_q   <= cur_rd_d;
    cur_ld_q   <= cur_ld_d;
  end

  assign s_axis_tready = (state_q == nqbc_pkg::StIdle);
  assign m_axis_tvalid = (state_q == nqbc_pkg::StDone);
  assign m_axis_tdata  = nqbc_pkg::OutDataW'(count_q);

endmodule

[sv/nqbc_chk.sv]
module nqbc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [nqbc_pkg::OutDataW-1:0] m_axis_tdata
);

  // A request makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("block still ready after taking a request");

  // The block never takes a request while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready for a request while a result is pending");

  // A taken result frees the block for the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> (s_axis_tready && !m_axis_tvalid))
    else $error("block not idle after the result was taken");

  // A stalled result holds its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind nqueens_bitmask_counter_core nqbc_chk u_nqbc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/nqbc_count_checker.sv]
// Watches the request, result and board size channels of the N-queens counter,
// predicts the solution count of every accepted request and compares it with
// the result stream in order.
module nqbc_count_checker
  import nqbc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [BoardSizeW-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [InDataW-1:0]     s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OutDataW-1:0]    m_axis_tdata,
  output int unsigned            pending_o,
  output int unsigned            failures_o,
  output int unsigned            results_o
);

  localparam int unsigned MaxBoard = 16;

  logic [BoardSizeW-1:0] board_size_q;
  logic [CountW-1:0]     expected_counts[$];
  logic [CountW-1:0]     oldest_count;
  int unsigned           mismatches = 0;
  int unsigned           results_seen = 0;
  int unsigned           waiting = 0;

  assign pending_o  = waiting;
  assign failures_o = mismatches;
  assign results_o  = results_seen;

  // Counts all solutions below one partial placement by walking the search
  // tree with an explicit stack, lowest free column first.
  function automatic logic [CountW-1:0] count_solutions(
    input logic [BoardSizeW-1:0] bsize,
    input logic [StartRowW-1:0]  start_row,
    input logic [MaskInW-1:0]    taken,
    input logic [MaskInW-1:0]    right_diag,
    input logic [MaskInW-1:0]    left_diag
  );
    int unsigned n;
    int unsigned full;
    int unsigned depth;
    int unsigned top;
    int unsigned avail;
    int unsigned bit_p;
    int unsigned count;
    int unsigned free_lvl[MaxBoard];
    int unsigned col_lvl[MaxBoard];
    int unsigned rd_lvl[MaxBoard];
    int unsigned ld_lvl[MaxBoard];
    n = (bsize > MaxBoard) ? MaxBoard : bsize;
    full = (n == 0) ? 0 : (32'd1 << n) - 1;
    depth = 0;
    count = 0;
    if (start_row < n) begin
      col_lvl[0]  = taken & full;
      rd_lvl[0]   = right_diag;
      ld_lvl[0]   = left_diag & full;
      free_lvl[0] = full & ~(col_lvl[0] | rd_lvl[0] | ld_lvl[0]);
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        avail = free_lvl[top];
        if (avail == 0) begin
          depth--;
        end else begin
          bit_p = avail & (~avail + 1);
          free_lvl[top] = avail ^ bit_p;
          if (start_row + top == n - 1) begin
            // A queen in the last row completes a solution; the count saturates.
            if (count != 32'hFFFF_FFFF) count++;
          end else if (depth < MaxBoard) begin
            col_lvl[depth]  = (col_lvl[top] | bit_p) & full;
            rd_lvl[depth]   = (rd_lvl[top] | bit_p) >> 1;
            ld_lvl[depth]   = ((ld_lvl[top] | bit_p) << 1) & full;
            free_lvl[depth] = full & ~(col_lvl[depth] | rd_lvl[depth] | ld_lvl[depth]);
            depth++;
          end
        end
      end
    end
    return count;
  endfunction

  // Requests add an expected count, results are checked against the oldest one,
  // and board size writes take effect for later requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q = BoardSizeRst;
      expected_counts.delete();
      waiting = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_counts.push_back(count_solutions(
          board_size_q,
          s_axis_tdata[StartRowW-1:0],
          s_axis_tdata[StartRowW +: MaskInW],
          s_axis_tdata[StartRowW + MaskInW +: MaskInW],
          s_axis_tdata[StartRowW + 2 * MaskInW +: MaskInW]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_counts.size() == 0) begin
          $error("solution_count: no request waiting, actual %0d",
                 m_axis_tdata[CountW-1:0]);
          mismatches++;
        end else begin
          oldest_count = expected_counts.pop_front();
          if (m_axis_tdata[CountW-1:0] !== oldest_count) begin
            $error("solution_count: expected %0d, actual %0d",
                   oldest_count, m_axis_tdata[CountW-1:0]);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) board_size_q = cfg_wdata_i;
      waiting = expected_counts.size();
    end
  end

endmodule

[verif/tb.sv]
module tb;
  import nqbc_pkg::*;

  localparam int     ClkPeriod     = 12;
  localparam longint TimeoutCycles = 10_000_000;
  localparam int     HoldCycles    = 400;
  localparam int     Phases        = 6;
  localparam int     PhaseItems    = 14;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [BoardSizeW-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;

  int unsigned           pending;
  int unsigned           failures;
  int unsigned           results;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           requests_sent;
  bit                    hold_pending;
  logic [BoardSizeW-1:0] board_now;

  nqueens_bitmask_counter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  nqbc_count_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .failures_o    (failures),
    .results_o     (results)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("tb: done, errors");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold when asked for.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request, with random idle cycles first, and returns at the
  // edge where it is accepted. Valid stays high for a back-to-back request.
  task automatic send_request(input logic [StartRowW-1:0] start_row,
                              input logic [MaskInW-1:0] cols,
                              input logic [MaskInW-1:0] rd,
                              input logic [MaskInW-1:0] ld);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({ld, rd, cols, start_row});
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Drops valid and waits until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // The board size is only changed while the block is idle.
  task automatic set_board_size(input logic [BoardSizeW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    board_now = value;
  endtask

  // Most requests are legal partial placements built row by row with random
  // column choices; the rest carry random masks. Large boards keep only the
  // last few rows open so that each search stays short.
  task automatic send_random_request(input logic [BoardSizeW-1:0] bsize);
    int unsigned      n;
    int unsigned      lo;
    int unsigned      start_row;
    int unsigned      avail_cnt;
    int unsigned      pick;
    logic [16:0]      full_w;
    logic [MaskInW-1:0] full;
    logic [MaskInW-1:0] cols;
    logic [MaskInW-1:0] rd;
    logic [MaskInW-1:0] ld;
    logic [MaskInW-1:0] avail;
    logic [MaskInW-1:0] bit_p;
    n = (bsize > 16) ? 16 : bsize;
    lo = (n <= 8) ? 0 : ((n <= 10) ? 2 : n - 3);
    full_w = (17'd1 << n) - 17'd1;
    full = full_w[MaskInW-1:0];
    if (n == 0 || $urandom_range(99) < 30) begin
      start_row = $urandom_range(15, lo);
      cols = MaskInW'($urandom);
      rd   = MaskInW'($urandom);
      ld   = MaskInW'($urandom);
    end else begin
      start_row = $urandom_range(n - 1, lo);
      cols = '0;
      rd   = '0;
      ld   = '0;
      for (int r = 0; r < start_row; r++) begin
        avail = full & ~(cols | rd | ld);
        // A dead end leaves the masks as they are: a placement with no way out.
        if (avail == '0) break;
        avail_cnt = $countones(avail);
        pick = $urandom_range(avail_cnt - 1);
        bit_p = '0;
        for (int b = 0; b < MaskInW; b++) begin
          if (avail[b] && bit_p == '0) begin
            if (pick == 0) bit_p[b] = 1'b1;
            else pick--;
          end
        end
        cols = cols | bit_p;
        rd   = (rd | bit_p) >> 1;
        ld   = ((ld | bit_p) << 1) & full;
      end
    end
    send_request(start_row[StartRowW-1:0], cols, rd, ld);
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_pending  = 1'b0;
    requests_sent = 0;
    board_now     = BoardSizeRst;
    send_idle_pct = 30;
    recv_idle_pct = 71;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed requests on the reset board size of eight.
    send_request(4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(4'd8, 16'h0000, 16'h0000, 16'h0000);
    send_request(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(4'd0, 16'hFF00, 16'h0000, 16'hFF00);
    send_request(4'd5, 16'h0000, 16'hFF00, 16'h0000);
    send_request(4'd0, 16'hFFFF, 16'h0000, 16'h0000);
    send_request(4'd7, 16'h00FE, 16'h0000, 16'h0000);

    // An empty board has no free column at all.
    set_board_size(5'd0);
    send_request(4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(4'd15, 16'h0000, 16'h0000, 16'h0000);

    // Single-column board.
    set_board_size(5'd1);
    send_request(4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(4'd1, 16'h0000, 16'h0000, 16'h0000);
    send_request(4'd0, 16'h0000, 16'h0002, 16'h0000);
    send_request(4'd0, 16'h0001, 16'h0000, 16'h0000);

    set_board_size(5'd4);
    send_request(4'd0, 16'h0000, 16'h0000, 16'h0000);

    // Widest board, only the last rows left open.
    set_board_size(5'd16);
    send_request(4'd15, 16'h0000, 16'h0000, 16'h0000);
    send_request(4'd14, 16'h5555, 16'hFFFF, 16'h0000);
    send_request(4'd13, 16'h0000, 16'h0000, 16'h0000);

    // Sizes past the widest board are clipped to it.
    set_board_size(5'd31);
    send_request(4'd13, 16'h0000, 16'h0000, 16'h0000);
    send_request(4'd15, 16'hAAAA, 16'h0000, 16'hFFFF);

    // Random phases: one board size each; the idle mix changes every second phase.
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph % 3)
        0:       set_board_size(BoardSizeW'($urandom_range(8, 2)));
        1:       set_board_size(BoardSizeW'($urandom_range(10, 5)));
        default: set_board_size(BoardSizeW'($urandom_range(31, 11)));
      endcase
      // With no idling, hold the result side so the block backs up.
      if (ph == 4) hold_pending = 1'b1;
      repeat (PhaseItems) send_random_request(board_now);
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("tb: %0d requests over board sizes 0 to 31, %0d counts checked",
             requests_sent, results);
    $display("tb: idle mixes on both sides and a %0d-cycle result stall", HoldCycles);
    if (failures == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
